// File: sv/megarom_bank_mapper_core_defines.svh
// Assertion macros used by the megarom bank mapper datapath.
`ifndef MEGAROM_BANK_MAPPER_CORE_DEFINES_SVH
`define MEGAROM_BANK_MAPPER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MBM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MBM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/mbm_pkg.sv
// Shared types and constants for the megarom bank mapper.
`timescale 1ns / 1ps

package mbm_pkg;

  // Mapper kinds held in the kind register.
  localparam logic [2:0] KIND_PLAIN      = 3'd0;
  localparam logic [2:0] KIND_KONAMI     = 3'd1;
  localparam logic [2:0] KIND_KONAMI_SCC = 3'd2;
  localparam logic [2:0] KIND_ASCII8     = 3'd3;
  localparam logic [2:0] KIND_ASCII16    = 3'd4;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_KIND = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE = 1'b1;

  // Result targets.
  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_ROM  = 2'd1;
  localparam logic [1:0] TGT_SCC  = 2'd2;

  // Widths and limits.
  localparam int SIZE_W   = 23;
  localparam int ROM_W    = 22;
  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 8;
  localparam int DIV_W    = 10;
  localparam int REM_W    = 9;
  localparam logic [SIZE_W-1:0] MAX_ROM_BYTES = 23'd4194304;
  localparam int SMALL_BANK_BYTES = 8192;
  localparam int LARGE_BANK_BYTES = 16384;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic calc;
    logic load_out;
  } mbm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } mbm_sts_t;

endpackage

// File: sv/mbm_rem.sv
// Remainder unit: bank number modulo the ROM page count.
`timescale 1ns / 1ps

module mbm_rem (
  input  logic                    clk,
  input  logic                    load,
  input  logic [mbm_pkg::DATA_W-1:0] dividend,
  input  logic [mbm_pkg::DIV_W-1:0]  divisor,
  output logic [mbm_pkg::REM_W-1:0]  rem
);
  import mbm_pkg::*;

  logic [REM_W-1:0] part;
  logic [3:0]       low_bits;
  logic [DIV_W-1:0] div_r;

  // Four restoring steps, one dividend bit each, most significant first.
  function automatic logic [REM_W-1:0] rem_steps4(input logic [REM_W-1:0] r_in,
                                                  input logic [3:0] bits,
                                                  input logic [DIV_W-1:0] dv);
    logic [DIV_W-1:0] t;
    logic [REM_W-1:0] r;
    r = r_in;
    for (int i = 3; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= dv) begin
        t = t - dv;
      end
      r = t[REM_W-1:0];
    end
    return r;
  endfunction

  // Upper half of the dividend is reduced at load, the lower half after.
  always_ff @(posedge clk) begin
    if (load) begin
      part     <= rem_steps4('0, dividend[7:4], divisor);
      low_bits <= dividend[3:0];
      div_r    <= divisor;
    end
  end

  assign rem = rem_steps4(part, low_bits, div_r);

endmodule

// File: sv/mbm_ctrl.sv
// Controller state machine sequencing one access through the datapath.
`timescale 1ns / 1ps

module mbm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  mbm_pkg::mbm_sts_t sts,
  output mbm_pkg::mbm_cmd_t cmd
);
  import mbm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  // Next state and commands.
  always_comb begin
    state_next   = state;
    cmd          = '0;
    s_tready     = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: sv/mbm_datapath.sv
// Datapath: configuration, bank registers, address decode and result register.
`timescale 1ns / 1ps
`include "megarom_bank_mapper_core_defines.svh"

module mbm_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mbm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mbm_pkg::SIZE_W-1:0]        cfg_wdata,
  input  logic [23:0]                       s_tdata,
  input  logic                              s_tuser,
  input  mbm_pkg::mbm_cmd_t                 cmd,
  output mbm_pkg::mbm_sts_t                 sts,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [39:0]                       m_tdata,
  output logic [1:0]                        m_tuser
);
  import mbm_pkg::*;

  typedef enum logic [2:0] {
    RK_NONE,
    RK_SCC,
    RK_PLAIN,
    RK_PAGE8,
    RK_PAGE16
  } res_kind_t;

  // Configuration state.
  logic [2:0]        kind_r;
  logic [SIZE_W-1:0] size_eff;
  logic [DIV_W-1:0]  count8;
  logic [DIV_W-1:0]  count16;

  // Bank registers.
  logic [DATA_W-1:0] konami_banks [4];
  logic [DATA_W-1:0] ascii8_banks [4];
  logic [DATA_W-1:0] ascii16_banks [2];

  // Captured access.
  logic              op_r;
  logic [ADDR_W-1:0] a_r;
  logic [DATA_W-1:0] d_r;
  res_kind_t         rk;

  // Result register.
  logic              out_valid;
  logic [1:0]        out_target;
  logic [ROM_W-1:0]  out_rom;
  logic [ADDR_W-1:0] out_scc;

  // Configuration write decode.
  logic [SIZE_W-1:0] wsize;
  logic [SIZE_W:0]   sum8;
  logic [SIZE_W:0]   sum16;

  always_comb begin
    wsize = (cfg_wdata > MAX_ROM_BYTES) ? MAX_ROM_BYTES : cfg_wdata;
    sum8  = {1'b0, wsize} + (SIZE_W+1)'(SMALL_BANK_BYTES - 1);
    sum16 = {1'b0, wsize} + (SIZE_W+1)'(LARGE_BANK_BYTES - 1);
  end

  // Page counts are kept alongside the clamped size.
  always_ff @(posedge clk) begin
    if (rst) begin
      kind_r   <= KIND_PLAIN;
      size_eff <= '0;
      count8   <= '0;
      count16  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KIND: kind_r <= cfg_wdata[2:0];
        REG_SIZE: begin
          size_eff <= wsize;
          count8   <= sum8[22:13];
          count16  <= {1'b0, sum16[22:14]};
        end
        default: ;
      endcase
    end
  end

  // Konami kinds mirror the low and high quarters into the middle half.
  logic              is_konami;
  logic [ADDR_W-1:0] in_addr;
  logic [ADDR_W-1:0] mirrored;

  always_comb begin
    is_konami = (kind_r == KIND_KONAMI) || (kind_r == KIND_KONAMI_SCC);
    in_addr   = s_tdata[15:0];
    mirrored  = in_addr;
    if (is_konami) begin
      case (in_addr[15:14])
        2'b00:   mirrored = {2'b10, in_addr[13:0]};
        2'b11:   mirrored = {2'b01, in_addr[13:0]};
        default: mirrored = in_addr;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= s_tuser;
      a_r  <= mirrored;
      d_r  <= s_tdata[23:16];
    end
  end

  // Access decode: bank register writes and read classification.
  logic              scc_win;
  logic              rom_win;
  logic              kb_we;
  logic [1:0]        kb_idx;
  logic [DATA_W-1:0] kb_val;
  logic              a8_we;
  logic [1:0]        a8_idx;
  logic              a16_we;
  logic              a16_idx;
  logic [1:0]        page8_idx;
  res_kind_t         rk_next;
  logic [DATA_W-1:0] bank_sel;
  logic [DIV_W-1:0]  div_sel;

  always_comb begin
    scc_win   = (kind_r == KIND_KONAMI_SCC) && (konami_banks[2][5:0] == 6'h3F) &&
                (a_r >= 16'h9800) && (a_r < 16'hA000);
    rom_win   = (a_r >= 16'h4000) && (a_r < 16'hC000);
    page8_idx = 2'(a_r[15:13] - 3'd2);
    kb_we     = 1'b0;
    kb_idx    = page8_idx;
    kb_val    = d_r;
    a8_we     = 1'b0;
    a8_idx    = a_r[12:11];
    a16_we    = 1'b0;
    a16_idx   = a_r[12];
    rk_next   = RK_NONE;
    bank_sel  = konami_banks[page8_idx];
    div_sel   = count8;
    if (op_r) begin
      // Writes load bank registers; only the SCC window gives a result.
      case (kind_r)
        KIND_KONAMI_SCC: begin
          kb_val = {2'b00, d_r[5:0]};
          if (scc_win) begin
            rk_next = RK_SCC;
          end else if (a_r >= 16'h5000 && a_r < 16'h5800) begin
            kb_we = 1'b1; kb_idx = 2'd0;
          end else if (a_r >= 16'h7000 && a_r < 16'h7800) begin
            kb_we = 1'b1; kb_idx = 2'd1;
          end else if (a_r >= 16'h9000 && a_r < 16'h9800) begin
            kb_we = 1'b1; kb_idx = 2'd2;
          end else if (a_r >= 16'hB000 && a_r < 16'hB800) begin
            kb_we = 1'b1; kb_idx = 2'd3;
          end
        end
        KIND_KONAMI: begin
          kb_we = (a_r >= 16'h6000) && (a_r < 16'hC000);
        end
        KIND_ASCII8: begin
          a8_we = (a_r >= 16'h6000) && (a_r < 16'h8000);
        end
        KIND_ASCII16: begin
          a16_we = (a_r >= 16'h6000) && (a_r < 16'h8000);
        end
        default: ;
      endcase
    end else if (size_eff != '0 && rom_win) begin
      // Reads in the cartridge window.
      if (is_konami) begin
        rk_next = scc_win ? RK_SCC : RK_PAGE8;
      end else if (kind_r == KIND_ASCII8) begin
        rk_next  = RK_PAGE8;
        bank_sel = ascii8_banks[page8_idx];
      end else if (kind_r == KIND_ASCII16) begin
        rk_next  = RK_PAGE16;
        bank_sel = ascii16_banks[a_r[15]];
        div_sel  = count16;
      end else begin
        rk_next = RK_PLAIN;
      end
    end
  end

  // Bank registers with their power-on mapping.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        konami_banks[i] <= DATA_W'(i);
        ascii8_banks[i] <= DATA_W'(i);
      end
      ascii16_banks[0] <= 8'd0;
      ascii16_banks[1] <= 8'd1;
    end else if (cmd.calc) begin
      if (kb_we) begin
        konami_banks[kb_idx] <= kb_val;
      end
      if (a8_we) begin
        ascii8_banks[a8_idx] <= d_r;
      end
      if (a16_we) begin
        ascii16_banks[a16_idx] <= d_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      rk <= rk_next;
    end
  end

  // Bank number modulo the page count.
  logic [REM_W-1:0] rem_val;

  mbm_rem u_rem (
    .clk      (clk),
    .load     (cmd.calc),
    .dividend (bank_sel),
    .divisor  (div_sel),
    .rem      (rem_val)
  );

  // Physical address and end-of-image check.
  logic [ADDR_W-1:0] plain_off;
  logic [ROM_W-1:0]  phys8;
  logic [ROM_W-1:0]  phys16;
  logic [1:0]        res_target;
  logic [ROM_W-1:0]  res_rom;
  logic [ADDR_W-1:0] res_scc;

  always_comb begin
    plain_off  = a_r - 16'h4000;
    phys8      = {rem_val, a_r[12:0]};
    phys16     = {rem_val[7:0], a_r[13:0]};
    res_target = TGT_NONE;
    res_rom    = '0;
    res_scc    = '0;
    case (rk)
      RK_SCC: begin
        res_target = TGT_SCC;
        res_scc    = a_r;
      end
      RK_PLAIN: begin
        if (SIZE_W'(plain_off) < size_eff) begin
          res_target = TGT_ROM;
          res_rom    = ROM_W'(plain_off);
        end
      end
      RK_PAGE8: begin
        if ({1'b0, phys8} < size_eff) begin
          res_target = TGT_ROM;
          res_rom    = phys8;
        end
      end
      RK_PAGE16: begin
        if ({1'b0, phys16} < size_eff) begin
          res_target = TGT_ROM;
          res_rom    = phys16;
        end
      end
      default: ;
    endcase
  end

  // Output register; a new item may load as the held one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_target <= res_target;
      out_rom    <= res_rom;
      out_scc    <= res_scc;
    end
  end

  assign sts.out_free = !out_valid || m_tready;
  assign m_tvalid     = out_valid;
  assign m_tuser      = out_target;
  assign m_tdata      = {2'b00, out_scc, out_rom};

  logic rom_in_range;
  assign rom_in_range = {1'b0, out_rom} < size_eff;

  `MBM_ASSERT_IMP(a_scc_no_rom, out_valid && out_target == TGT_SCC, out_rom == '0, "SCC result carries a ROM address")
  `MBM_ASSERT_IMP(a_rom_no_scc, out_valid && out_target != TGT_SCC, out_scc == '0, "non-SCC result carries an SCC address")
  `MBM_ASSERT_IMP(a_rom_in_image, out_valid && out_target == TGT_ROM, rom_in_range, "ROM hit beyond the image")
  `MBM_ASSERT_NXT(a_konami_bank0_fixed, cmd.calc && kind_r == KIND_KONAMI, $stable(konami_banks[0]), "plain Konami wrote bank 0")

endmodule

// File: sv/megarom_bank_mapper_core.sv
// Top level of the megarom cartridge bank mapper.
`timescale 1ns / 1ps
// Usage:
//   One CPU access to the cartridge slot enters on the s_ stream per item:
//   s_tuser is the access kind (1 write), s_tdata carries address and data.
//   One result leaves on the m_ stream for every accepted item: m_tuser is
//   the target (none, ROM hit, SCC access), m_tdata the ROM and SCC address.
//   Mapper kind and ROM size are written on the cfg_ port while no access
//   is in flight; a write takes effect on the next cycle.
// Sequencing:
//   An item is captured in S_IDLE. In S_CALC it is decoded and the upper
//   half of the bank number is reduced modulo the page count; in S_DONE the
//   lower half is finished and the result register loads once it is free.
//   A new item is accepted only when the controller is back in S_IDLE.
// Reset and back-pressure:
//   Reset empties the result register, sets plain mapping with no ROM and
//   restores the bank registers to their power-on pages. While m_tready is
//   low the result is held; a following item is still accepted and waits
//   in the datapath until the result register frees.

module megarom_bank_mapper_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mbm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mbm_pkg::SIZE_W-1:0]      cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [23:0]                     s_tdata,   // address[15:0], wr_byte[23:16]
  input  logic                            s_tuser,   // op[0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [39:0]                     m_tdata,   // rom_address[21:0], scc_address[37:22]
  output logic [1:0]                      m_tuser    // target[1:0]
);
  import mbm_pkg::*;

  mbm_cmd_t cmd;
  mbm_sts_t sts;

  mbm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mbm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
